@@ rtl/gf2rb_pkg.sv @@
// Package with shared constants for the GF(2) incremental rank basis block.
`timescale 1ns / 1ps

package gf2rb_pkg;

    // Fixed width of the row field on the input port.
    localparam int ROW_BITS = 64;

    // Default number of active columns in the basis.
    localparam int DEF_ROW_WIDTH = 64;

    // Fixed widths of the result fields.
    localparam int PIDX_BITS = 6;
    localparam int RANK_BITS = 7;

endpackage

@@ rtl/gf2_incremental_rank_basis.sv @@
// Incremental GF(2) row basis with pivot rows keyed by their lowest set bit.
// A clear item goes through the lookup state to its result. An insert item also makes
// a pivot memory read and an XOR into the row for every stored pivot that it meets.
// One item at a time: the input stalls until the result is loaded, and each step of the
// reduction walk is a pivot memory read followed by the XOR back into the working row.
// Reset clears the valid marks, the rank, the state and the output valid flag; the pivot
// memory itself is not cleared, and an entry is read only once its valid mark is set.
`timescale 1ns / 1ps

module gf2_incremental_rank_basis #(
    parameter int ROW_WIDTH = gf2rb_pkg::DEF_ROW_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input channel.
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_func,
    input  logic [gf2rb_pkg::ROW_BITS-1:0]  i_row_bits,
    // Result channel.
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_independent,
    output logic [gf2rb_pkg::PIDX_BITS-1:0] o_pivot_index,
    output logic [gf2rb_pkg::RANK_BITS-1:0] o_rank
);

    localparam int IDX_W = $clog2(ROW_WIDTH);
    localparam int RK_W  = $clog2(ROW_WIDTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIND,
        S_WAIT
    } t_state;

    t_state                r_state;
    logic                  r_clr;
    logic [ROW_WIDTH-1:0]  r_row;
    logic [ROW_WIDTH-1:0]  r_valid;
    logic [RK_W-1:0]       r_rank;
    logic [ROW_WIDTH-1:0]  r_rdata;
    logic                  r_out_valid;
    logic                  r_out_indep;
    logic [IDX_W-1:0]      r_out_pidx;
    logic [RK_W-1:0]       r_out_rank;

    logic [ROW_WIDTH-1:0]  mem_pivot [ROW_WIDTH];

    logic [IDX_W-1:0]      low_idx;
    logic                  row_zero;
    logic                  out_free;
    logic                  out_load;
    logic                  in_accept;
    logic                  mem_we;
    logic                  mem_re;
    logic [RK_W-1:0]       n_rank;

    // Lowest set bit of the working row.
    always_comb begin
        low_idx = '0;
        for (int i = ROW_WIDTH - 1; i >= 0; i--) begin
            if (r_row[i]) begin
                low_idx = IDX_W'(i);
            end
        end
    end

    assign row_zero  = (r_row == '0);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign n_rank    = r_rank + RK_W'(1);

    // A result is loaded when the walk ends and the result register is free.
    assign out_load = (r_state == S_FIND) && out_free
                      && (r_clr || row_zero || !r_valid[low_idx]);

    // A pivot is read when the lowest bit already has one, written when it does not.
    assign mem_re = (r_state == S_FIND) && !r_clr && !row_zero && r_valid[low_idx];
    assign mem_we = (r_state == S_FIND) && !r_clr && !row_zero && !r_valid[low_idx]
                    && out_free;

    // Pivot row memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_pivot[low_idx] <= r_row;
        end
        if (mem_re) begin
            r_rdata <= mem_pivot[low_idx];
        end
    end

    // Sequencer, basis bookkeeping and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_rank      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_clr   <= i_func;
                        r_row   <= i_row_bits[ROW_WIDTH-1:0];
                        r_state <= S_FIND;
                    end
                end
                S_FIND: begin
                    priority if (r_clr) begin
                        if (out_free) begin
                            r_valid     <= '0;
                            r_rank      <= '0;
                            r_out_indep <= 1'b0;
                            r_out_pidx  <= '0;
                            r_out_rank  <= '0;
                            r_state     <= S_IDLE;
                        end
                    end else if (row_zero) begin
                        if (out_free) begin
                            r_out_indep <= 1'b0;
                            r_out_pidx  <= '0;
                            r_out_rank  <= r_rank;
                            r_state     <= S_IDLE;
                        end
                    end else if (r_valid[low_idx]) begin
                        r_state <= S_WAIT;
                    end else begin
                        if (out_free) begin
                            r_valid[low_idx] <= 1'b1;
                            r_rank           <= n_rank;
                            r_out_indep      <= 1'b1;
                            r_out_pidx       <= low_idx;
                            r_out_rank       <= n_rank;
                            r_state          <= S_IDLE;
                        end
                    end
                end
                S_WAIT: begin
                    // Fold the stored pivot into the row; this clears its lowest bit.
                    r_row   <= r_row ^ r_rdata;
                    r_state <= S_FIND;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_independent = r_out_indep;
    assign o_pivot_index = gf2rb_pkg::PIDX_BITS'(r_out_pidx);
    assign o_rank        = gf2rb_pkg::RANK_BITS'(r_out_rank);

`ifndef SYNTHESIS
    // The rank always equals the number of valid pivot columns.
    a_rank_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_rank))
        else $error("rank count differs from number of valid pivots");

    // A memory read is only ever waited on right after a lookup.
    a_wait_after_find: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) |-> ($past(r_state) == S_FIND))
        else $error("read wait entered without a pivot lookup");

    // A new pivot result never reports an empty basis.
    a_indep_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_independent) |-> (o_rank != '0))
        else $error("independent item reported with zero rank");
`endif

endmodule
